FILE: rtl/core/guidance_blend_bf16_macros.svh
// Assertion macros used by guidance_blend_bf16.sv.
`ifndef GUIDANCE_BLEND_BF16_MACROS_SVH
`define GUIDANCE_BLEND_BF16_MACROS_SVH

`ifndef SYNTHESIS
`define GBB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define GBB_ASSERT_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define GBB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define GBB_ASSERT_NXT(lbl, clk, ante, cons, msg)
`endif

`endif

FILE: rtl/core/gbb_pkg.sv
`default_nettype none
package gbb_pkg;

    localparam logic [31:0] ScaleReset = 32'h3f80_0000;
    localparam logic [31:0] ExpMask    = 32'h7f80_0000;
    localparam logic [31:0] RoundHalf  = 32'h0000_7fff;
    localparam logic [31:0] HighMask   = 32'hffff_0000;
    localparam logic [31:0] CanonNan   = 32'h7fc0_0000;
    localparam logic [30:0] InfMag     = 31'h7f80_0000;
    localparam int          UnitLat    = 4;
    localparam int          DlyLen     = 2 * UnitLat;

    typedef struct packed {
        logic nan;
        logic inf;
        logic sign;
    } t_spec;

    // Round a binary32 to the bf16 grid; infinity and NaN are only truncated.
    function automatic logic [31:0] bf16_round(input logic [31:0] b);
        if ((b & ExpMask) != ExpMask) begin
            return (b + RoundHalf + {31'd0, b[16]}) & HighMask;
        end
        return b & HighMask;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 6'd1;
                end
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gbb_in_if.sv
`default_nettype none
interface gbb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] cond_pred;
    logic [31:0] uncond_pred;
    modport source (output valid, output cond_pred, output uncond_pred, input ready);
    modport sink (input valid, input cond_pred, input uncond_pred, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/gbb_out_if.sv
`default_nettype none
interface gbb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] guided_value;
    modport source (output valid, output guided_value, input ready);
    modport sink (input valid, input guided_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/gbb_fadd.sv
`default_nettype none
module gbb_fadd
    import gbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_vld,
    output logic [31:0]      o_res
);

    // stage 1: classify, order by magnitude, align
    logic        n1_swap;
    logic [31:0] n1_big, n1_sml;
    logic [7:0]  n1_eb, n1_es, n1_d;
    logic [4:0]  n1_dsh;
    logic [53:0] n1_wide;
    logic        n1_anan, n1_bnan, n1_ainf, n1_binf;
    t_spec       n1_spec;

    logic        r1_vld, r1_sign, r1_sub;
    t_spec       r1_spec;
    logic [7:0]  r1_e;
    logic [26:0] r1_mb, r1_ms;

    always_comb begin
        n1_anan = (&i_a[30:23]) & (|i_a[22:0]);
        n1_bnan = (&i_b[30:23]) & (|i_b[22:0]);
        n1_ainf = (&i_a[30:23]) & ~(|i_a[22:0]);
        n1_binf = (&i_b[30:23]) & ~(|i_b[22:0]);
        n1_swap = i_b[30:0] > i_a[30:0];
        n1_big  = n1_swap ? i_b : i_a;
        n1_sml  = n1_swap ? i_a : i_b;
        n1_eb   = (n1_big[30:23] == 8'd0) ? 8'd1 : n1_big[30:23];
        n1_es   = (n1_sml[30:23] == 8'd0) ? 8'd1 : n1_sml[30:23];
        n1_d    = n1_eb - n1_es;
        n1_dsh  = (n1_d > 8'd27) ? 5'd27 : n1_d[4:0];
        n1_wide = {|n1_sml[30:23], n1_sml[22:0], 3'b000, 27'd0} >> n1_dsh;
        n1_spec.nan  = n1_anan | n1_bnan | (n1_ainf & n1_binf & (i_a[31] ^ i_b[31]));
        n1_spec.inf  = n1_ainf | n1_binf;
        n1_spec.sign = n1_ainf ? i_a[31] : i_b[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
        if (i_en) begin
            r1_spec <= n1_spec;
            r1_sign <= n1_big[31];
            r1_sub  <= i_a[31] ^ i_b[31];
            r1_e    <= n1_eb;
            r1_mb   <= {|n1_big[30:23], n1_big[22:0], 3'b000};
            r1_ms   <= {n1_wide[53:28], n1_wide[27] | (|n1_wide[26:0])};
        end
    end

    // stage 2: add or subtract, count leading zeros
    logic [27:0] n2_sum;
    logic        r2_vld, r2_sign;
    t_spec       r2_spec;
    logic [7:0]  r2_e;
    logic [27:0] r2_sum;
    logic [5:0]  r2_lz;

    assign n2_sum = r1_sub ? ({1'b0, r1_mb} - {1'b0, r1_ms}) : ({1'b0, r1_mb} + {1'b0, r1_ms});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_spec <= r1_spec;
            // exact cancellation gives +0
            r2_sign <= (r1_sub && n2_sum == 28'd0) ? 1'b0 : r1_sign;
            r2_e    <= r1_e;
            r2_sum  <= n2_sum;
            r2_lz   <= lzc48({n2_sum, 20'hfffff});
        end
    end

    // stage 3: normalize, stop at the subnormal exponent
    logic [8:0]  n3_lzm1, n3_em1, n3_sh, n3_enew;
    logic [26:0] n3_m;
    logic [8:0]  n3_field;
    logic        r3_vld, r3_sign;
    t_spec       r3_spec;
    logic [26:0] r3_m;
    logic [8:0]  r3_field;

    always_comb begin
        n3_lzm1 = {3'b000, r2_lz} - 9'd1;
        n3_em1  = {1'b0, r2_e} - 9'd1;
        n3_sh   = (n3_lzm1 > n3_em1) ? n3_em1 : n3_lzm1;
        n3_enew = {1'b0, r2_e} - n3_sh;
        if (r2_sum[27]) begin
            n3_m     = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            n3_field = {1'b0, r2_e} + 9'd1;
        end else begin
            n3_m     = r2_sum[26:0] << n3_sh;
            n3_field = n3_m[26] ? n3_enew : 9'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r3_spec  <= r2_spec;
            r3_sign  <= r2_sign;
            r3_m     <= n3_m;
            r3_field <= n3_field;
        end
    end

    // stage 4: round to nearest even, pack, round to bf16
    logic        n4_inc;
    logic [30:0] n4_mag;
    logic [31:0] n4_res;
    logic        r4_vld;
    logic [31:0] r4_res;

    always_comb begin
        n4_inc = r3_m[2] & (r3_m[1] | r3_m[0] | r3_m[3]);
        n4_mag = {r3_field[7:0], r3_m[25:3]} + {30'd0, n4_inc};
        if (r3_spec.nan) begin
            n4_res = CanonNan;
        end else if (r3_spec.inf) begin
            n4_res = {r3_spec.sign, InfMag};
        end else if (r3_field >= 9'd255) begin
            n4_res = {r3_sign, InfMag};
        end else begin
            n4_res = {r3_sign, n4_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
        if (i_en) begin
            r4_res <= bf16_round(n4_res);
        end
    end

    assign o_vld = r4_vld;
    assign o_res = r4_res;

endmodule
`default_nettype wire

FILE: rtl/core/gbb_fmul.sv
`default_nettype none
module gbb_fmul
    import gbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_vld,
    output logic [31:0]      o_res
);

    // stage 1: classify and multiply significands
    logic        n1_anan, n1_bnan, n1_ainf, n1_binf, n1_az, n1_bz;
    logic [7:0]  n1_ea, n1_eb;
    t_spec       n1_spec;
    logic        r1_vld, r1_zero;
    t_spec       r1_spec;
    logic [47:0] r1_p;
    logic [8:0]  r1_esum;

    always_comb begin
        n1_anan = (&i_a[30:23]) & (|i_a[22:0]);
        n1_bnan = (&i_b[30:23]) & (|i_b[22:0]);
        n1_ainf = (&i_a[30:23]) & ~(|i_a[22:0]);
        n1_binf = (&i_b[30:23]) & ~(|i_b[22:0]);
        n1_az   = i_a[30:0] == 31'd0;
        n1_bz   = i_b[30:0] == 31'd0;
        n1_ea   = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
        n1_eb   = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
        n1_spec.nan  = n1_anan | n1_bnan | (n1_ainf & n1_bz) | (n1_binf & n1_az);
        n1_spec.inf  = n1_ainf | n1_binf;
        n1_spec.sign = i_a[31] ^ i_b[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
        if (i_en) begin
            r1_spec <= n1_spec;
            r1_zero <= n1_az | n1_bz;
            r1_p    <= {|i_a[30:23], i_a[22:0]} * {|i_b[30:23], i_b[22:0]};
            r1_esum <= {1'b0, n1_ea} + {1'b0, n1_eb};
        end
    end

    // stage 2: normalize the product, form the biased exponent
    logic [5:0]         n2_lz;
    logic               r2_vld, r2_zero;
    t_spec              r2_spec;
    logic [47:0]        r2_p;
    logic signed [10:0] r2_e;

    assign n2_lz = lzc48(r1_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_spec <= r1_spec;
            r2_zero <= r1_zero;
            r2_p    <= r1_p << n2_lz;
            r2_e    <= $signed({2'b00, r1_esum}) - 11'sd126 - $signed({5'd0, n2_lz});
        end
    end

    // stage 3: denormalize on underflow
    logic [5:0]  n3_sh;
    logic [95:0] n3_wide;
    logic        n3_tiny;
    logic        r3_vld, r3_zero, r3_ovf, r3_st;
    t_spec       r3_spec;
    logic [47:0] r3_q;
    logic [7:0]  r3_field;

    always_comb begin
        n3_tiny = r2_e <= 11'sd0;
        n3_sh   = (r2_e < -11'sd47) ? 6'd49 : 6'(11'sd1 - r2_e);
        n3_wide = {r2_p, 48'd0} >> (n3_tiny ? n3_sh : 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r3_spec  <= r2_spec;
            r3_zero  <= r2_zero;
            r3_ovf   <= r2_e >= 11'sd255;
            r3_q     <= n3_wide[95:48];
            r3_st    <= |n3_wide[47:0];
            r3_field <= n3_tiny ? 8'd0 : r2_e[7:0];
        end
    end

    // stage 4: round to nearest even, pack, round to bf16
    logic        n4_inc;
    logic [30:0] n4_mag;
    logic [31:0] n4_res;
    logic        r4_vld;
    logic [31:0] r4_res;

    always_comb begin
        n4_inc = r3_q[23] & ((|r3_q[22:0]) | r3_st | r3_q[24]);
        n4_mag = {r3_field, r3_q[46:24]} + {30'd0, n4_inc};
        if (r3_spec.nan) begin
            n4_res = CanonNan;
        end else if (r3_spec.inf) begin
            n4_res = {r3_spec.sign, InfMag};
        end else if (r3_zero) begin
            n4_res = {r3_spec.sign, 31'd0};
        end else if (r3_ovf) begin
            n4_res = {r3_spec.sign, InfMag};
        end else begin
            n4_res = {r3_spec.sign, n4_mag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
        if (i_en) begin
            r4_res <= bf16_round(n4_res);
        end
    end

    assign o_vld = r4_vld;
    assign o_res = r4_res;

endmodule
`default_nettype wire

FILE: rtl/core/guidance_blend_bf16.sv
// A request passes through three 4-stage fp units before its result is valid.
// Throughput: one request per cycle while the result is not stalled; the three units are chained in one pipeline.
// A stalled result freezes every stage at once; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and sets the scale to 1.0.
`default_nettype none
`include "guidance_blend_bf16_macros.svh"
module guidance_blend_bf16
    import gbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gbb_in_if.sink           i_in,
    gbb_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    logic        w_en;
    logic [31:0] r_scale;
    logic [31:0] r_unc_dly [DlyLen];
    logic        w_dvld, w_svld, w_gvld;
    logic [31:0] w_delta, w_scaled, w_guided;

    // advance the whole pipe unless the result is held
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ScaleReset;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_unc_dly[0] <= i_in.uncond_pred;
            for (int i = 1; i < DlyLen; i++) begin
                r_unc_dly[i] <= r_unc_dly[i - 1];
            end
        end
    end

    gbb_fadd u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_a     (i_in.cond_pred),
        .i_b     ({~i_in.uncond_pred[31], i_in.uncond_pred[30:0]}),
        .o_vld   (w_dvld),
        .o_res   (w_delta)
    );

    gbb_fmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dvld),
        .i_a     (w_delta),
        .i_b     (r_scale),
        .o_vld   (w_svld),
        .o_res   (w_scaled)
    );

    gbb_fadd u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_svld),
        .i_a     (r_unc_dly[DlyLen - 1]),
        .i_b     (w_scaled),
        .o_vld   (w_gvld),
        .o_res   (w_guided)
    );

    assign o_out.valid        = w_gvld;
    assign o_out.guided_value = w_guided[31:16];

    `GBB_ASSERT_IMP(a_stall_blocks_in, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready, "request taken while result stalled")
    `GBB_ASSERT_IMP(a_empty_takes_in, i_clk, i_rst_n, !o_out.valid, i_in.ready, "pipe not accepting with empty output")
    `GBB_ASSERT_NXT(a_reset_clears, i_clk, !i_rst_n, !o_out.valid, "result valid right after reset")

endmodule
`default_nettype wire

FILE: bench/gbb_tb_pkg.sv
`timescale 1ns / 100ps
package gbb_tb_pkg;

    localparam logic [31:0] F32_CANON_NAN = 32'h7fc0_0000;
    localparam logic [31:0] F32_INF_MAG   = 32'h7f80_0000;

    // Widen a binary32 pattern to a real, subnormals included.
    function automatic real f32_to_real(input logic [31:0] b);
        logic [7:0]  e;
        logic [23:0] m;
        int          x;
        e = b[30:23];
        m = {1'b0, b[22:0]};
        if (e == 8'hff) begin
            if (m != 0) return $bitstoreal(64'h7ff8_0000_0000_0000);
            return $bitstoreal({b[31], 11'h7ff, 52'd0});
        end
        if (e == 8'd0) begin
            if (m == 0) return $bitstoreal({b[31], 63'd0});
            x = -126;
            while (!m[23]) begin
                m = m << 1;
                x = x - 1;
            end
        end else begin
            m[23] = 1'b1;
            x = int'(e) - 127;
        end
        return $bitstoreal({b[31], 11'(x + 1023), m[22:0], 29'd0});
    endfunction

    // Round a real to binary32, nearest even, subnormals kept; NaN is canonical.
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] d;
        logic [63:0] sig, kept, rem, half;
        logic [31:0] mag;
        int          x, sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7ff) begin
            if (d[51:0] != 0) return F32_CANON_NAN;
            return {d[63], 31'(F32_INF_MAG)};
        end
        if (d[62:52] == 11'd0) return {d[63], 31'd0};
        x = int'(d[62:52]) - 1023;
        if (x > 127) return {d[63], 31'(F32_INF_MAG)};
        sig = {11'd0, 1'b1, d[51:0]};
        sh = (x >= -126) ? 29 : 29 + (-126 - x);
        if (sh > 54) return {d[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        if (x >= -126) begin
            mag = 32'((x + 127) << 23) + 32'(kept - 64'h80_0000);
            if (mag >= F32_INF_MAG) mag = F32_INF_MAG;
        end else begin
            mag = 32'(kept);
        end
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] to_bf16_grid(input logic [31:0] b);
        if (b[30:23] != 8'hff) return (b + 32'h7fff + {31'd0, b[16]}) & 32'hffff_0000;
        return b & 32'hffff_0000;
    endfunction

    // Expected guided element for one request.
    function automatic logic [15:0] blend_guided(input logic [31:0] cond_bits,
                                                 input logic [31:0] uncond_bits,
                                                 input logic [31:0] scale_bits);
        logic [31:0] delta, scaled, guided;
        real         u;
        u      = f32_to_real(uncond_bits);
        delta  = to_bf16_grid(real_to_f32(f32_to_real(cond_bits) - u));
        scaled = to_bf16_grid(real_to_f32(f32_to_real(scale_bits) * f32_to_real(delta)));
        guided = to_bf16_grid(real_to_f32(u + f32_to_real(scaled)));
        return guided[31:16];
    endfunction

endpackage

FILE: bench/tb_guidance_blend_bf16.sv
`timescale 1ns / 100ps
module tb_guidance_blend_bf16;
    import gbb_tb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    gbb_in_if  in_ch ();
    gbb_out_if out_ch ();

    guidance_blend_bf16 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    logic [31:0] scale_now;
    logic [15:0] guided_expected[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatch_count;
    int          results_seen;
    int          requests_sent;
    int          cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Check each result and stall the output at random.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (guided_expected.size() == 0) begin
                report_mismatch("unexpected result", out_ch.guided_value, 16'h0);
            end else begin
                if (out_ch.guided_value !== guided_expected[0]) begin
                    report_mismatch("guided_value", out_ch.guided_value, guided_expected[0]);
                end
                void'(guided_expected.pop_front());
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input logic [31:0] c, input logic [31:0] u);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cond_pred   <= c;
        in_ch.uncond_pred <= u;
        do @(posedge i_clk); while (!in_ch.ready);
        guided_expected.insert(guided_expected.size(), blend_guided(c, u, scale_now));
        requests_sent++;
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (guided_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [31:0] s);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scale_now = s;
    endtask

    function automatic logic [31:0] pick_float();
        logic [31:0] b;
        b = $urandom();
        if ($urandom_range(3) != 0) b[30:23] = 8'($urandom_range(112, 140));
        return b;
    endfunction

    task automatic test_directed();
        logic [31:0] specials[14];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                     32'h7fc0_0000, 32'hffa0_0001, 32'h0000_0001, 32'h807f_ffff,
                     32'h7f7f_ffff, 32'hff7f_ffff, 32'h3f80_0000, 32'h7f7f_8000,
                     32'h3f80_8000, 32'h3f81_8000};
        // cover NaN inputs, inf - inf, extremes, rounding ties and carry to infinity
        for (int k = 0; k < 14; k++) send_request(specials[k], specials[(k * 5 + 3) % 14]);
        send_request(32'h7f80_0000, 32'h7f80_0000);
        send_request(32'h7f7f_ffff, 32'h0000_0000);
        send_request(32'hffff_ffff, 32'hffff_ffff);
        write_scale(32'h7f80_0000);
        send_request(32'h3f80_0000, 32'h3f80_0000);   // zero times infinity
        send_request(32'h4000_0000, 32'h3f80_0000);
        write_scale(32'h7f7f_ffff);
        send_request(32'h4000_0000, 32'h3f80_0000);   // product overflows
        send_request(32'h0000_0001, 32'h0000_0000);
        write_scale(32'h0000_0001);
        send_request(32'h3f80_0000, 32'h0000_0000);   // product underflows
    endtask

    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        logic [31:0] c, u, s;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 0) begin
                case ($urandom_range(5))
                    0: s = $urandom();
                    1: s = 32'h3f80_0000;
                    2: s = {$urandom_range(1) == 1, 31'd0};
                    3: s = 32'hffff_ffff;
                    default: s = {1'b0, 8'($urandom_range(120, 132)), 23'($urandom())};
                endcase
                write_scale(s);
            end
            if (k == n_items / 2) wait_drain();   // hold until every result is back
            c = ($urandom_range(7) == 0) ? $urandom() : pick_float();
            case ($urandom_range(3))
                0: u = c ^ 32'($urandom_range(0, 32'h1ffff));   // near cancellation
                1: u = $urandom();
                default: u = pick_float();
            endcase
            send_request(c, u);
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 32'd0;
        in_ch.valid       <= 1'b0;
        in_ch.cond_pred   <= 32'd0;
        in_ch.uncond_pred <= 32'd0;
        scale_now      = 32'h3f80_0000;
        send_idle_pct  = 8;
        recv_stall_pct = 86;
        mismatch_count = 0;
        results_seen   = 0;
        requests_sent  = 0;
        cycle_count    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(430, 8, 86);
        test_random(430, 86, 8);
        test_random(440, 0, 0);

        $display("covered %0d requests and %0d results over several guidance scales,",
                 requests_sent, results_seen);
        $display("special values, rounding carries and random stalls on both sides");
        if (mismatch_count == 0 && guided_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
